// ----- design/rtc_pkg.sv -----
// Shared types and constants for the RSSI triple collector.
package rtc_pkg;

   localparam int MAC_WIDTH             = 48;
   localparam int LEVEL_WIDTH           = 8;
   localparam int SNIFFER_COUNT         = 3;
   localparam int DEFAULT_TABLE_ENTRIES = 16;

   typedef logic [MAC_WIDTH-1:0]          mac_type;
   typedef logic signed [LEVEL_WIDTH-1:0] level_type;
   typedef logic [1:0]                    sniffer_type;
   typedef logic [SNIFFER_COUNT-1:0]      marks_type;

   localparam sniffer_type SNIFFER_UNKNOWN = 2'd3;
   localparam marks_type   ALL_REPORTED    = 3'b111;

   typedef struct packed {
      mac_type                      mac;
      level_type [SNIFFER_COUNT-1:0] levels;
      marks_type                    reported;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

// ----- design/rtc_if.sv -----
// Valid/ready channel interfaces for report and result beats.
interface rtc_req_if;
   rtc_pkg::mac_type     device_mac;
   rtc_pkg::sniffer_type sniffer_id;
   rtc_pkg::level_type   signal_level;
   logic                 valid;
   logic                 ready;

   modport source (output valid, device_mac, sniffer_id, signal_level, input ready);
   modport sink   (input valid, device_mac, sniffer_id, signal_level, output ready);
endinterface

interface rtc_rsp_if;
   rtc_pkg::mac_type   out_mac;
   rtc_pkg::level_type level_first;
   rtc_pkg::level_type level_second;
   rtc_pkg::level_type level_third;
   logic               valid;
   logic               ready;

   modport source (output valid, out_mac, level_first, level_second, level_third,
                   input ready);
   modport sink   (input valid, out_mac, level_first, level_second, level_third,
                   output ready);
endinterface

// ----- design/rssi_triple_collector.sv -----
// Top level: collects three sniffer RSSI reports per MAC in a scanned table.
//
//   channel   dir   beat contents
//   req_bus   in    device_mac, sniffer_id, signal_level
//   rsp_bus   out   out_mac, level_first, level_second, level_third
//
// A report from an unknown sniffer is dropped without a scan. Otherwise the
// entries in use are read one per cycle through the single read port of the
// entry memory; a match is written back in the commit state, else a new entry
// is appended if the table is not full. A result waits in an output register;
// the next report is taken meanwhile, and only a completing commit waits for
// that register to drain. Synchronous reset clears the entry count, no
// memory clearing pass is needed.
module rssi_triple_collector
   #(parameter int TABLE_ENTRIES = rtc_pkg::DEFAULT_TABLE_ENTRIES)
   (input  logic          clock,
    input  logic          reset,
    rtc_req_if.sink       req_bus,
    rtc_rsp_if.source     rsp_bus);

   import rtc_pkg::*;

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   entry_type entry_mem [TABLE_ENTRIES];

   state_type   state_ff, state_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] rd_idx_ff;
   logic          rd_live_ff, rd_live_in;
   entry_type     rd_ff;
   mac_type       mac_ff;
   sniffer_type   sniffer_ff;
   level_type     level_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   mac_type       out_mac_ff;
   level_type [SNIFFER_COUNT-1:0] out_levels_ff;

   logic          req_ready;
   logic          accept;
   logic          hit;
   logic          rd_load;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   entry_type     merged;
   entry_type     fresh;
   logic          complete;
   logic          out_load;

   assign accept = req_bus.valid && req_ready;
   assign hit    = rd_live_ff && (rd_ff.mac == mac_ff);

   always_comb begin
      merged                     = rd_ff;
      merged.levels[sniffer_ff]  = level_ff;
      merged.reported            = rd_ff.reported | marks_type'(3'b001 << sniffer_ff);
      complete                   = (merged.reported == ALL_REPORTED);
      if (complete) begin
         merged.reported = '0;
      end
      fresh                      = '0;
      fresh.mac                  = mac_ff;
      fresh.levels[sniffer_ff]   = level_ff;
      fresh.reported             = marks_type'(3'b001 << sniffer_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      scan_idx_in  = scan_idx_ff;
      rd_live_in   = rd_live_ff;
      req_ready    = 1'b0;
      rd_load      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = used_ff[IW-1:0];
      mem_wdata    = fresh;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            scan_idx_in = '0;
            rd_live_in  = 1'b0;
            if (accept && req_bus.sniffer_id != SNIFFER_UNKNOWN) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_COMMIT;
            end else if (!rd_live_ff && scan_idx_ff >= used_ff) begin
               state_in = ST_IDLE;
               if (used_ff < CW'(TABLE_ENTRIES)) begin
                  mem_we  = 1'b1;
                  used_in = used_ff + CW'(1);
               end
            end else begin
               rd_load    = 1'b1;
               rd_live_in = scan_idx_ff < used_ff;
               if (scan_idx_ff < used_ff) begin
                  scan_idx_in = scan_idx_ff + CW'(1);
               end
            end
         end
         ST_COMMIT: begin
            mem_waddr = rd_idx_ff[IW-1:0];
            mem_wdata = merged;
            if (!(complete && rsp_valid_ff && !rsp_bus.ready)) begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
               if (complete) begin
                  out_load     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      rd_live_ff  <= rd_live_in;
      if (accept) begin
         mac_ff     <= req_bus.device_mac;
         sniffer_ff <= req_bus.sniffer_id;
         level_ff   <= req_bus.signal_level;
      end
      if (rd_load) begin
         rd_ff     <= entry_mem[scan_idx_ff[IW-1:0]];
         rd_idx_ff <= scan_idx_ff;
      end
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (out_load) begin
         out_mac_ff    <= rd_ff.mac;
         out_levels_ff <= merged.levels;
      end
   end

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_mac      = out_mac_ff;
   assign rsp_bus.level_first  = out_levels_ff[0];
   assign rsp_bus.level_second = out_levels_ff[1];
   assign rsp_bus.level_third  = out_levels_ff[2];

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   a_unknown_drop: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.sniffer_id == SNIFFER_UNKNOWN |=> state_ff == ST_IDLE)
      else $error("unknown sniffer report started a scan");

   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_COMMIT)
      else $error("result raised outside a commit");

   a_commit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> rd_idx_ff < used_ff)
      else $error("commit to an unused entry");

endmodule
